### rtl/mmtile_pkg.sv
// Package for the 4x4 outer-product tile unit: widths, tdata field offsets,
// item kinds and the saturating add helpers. No dependencies.
`default_nettype none

package mmtile_pkg;

  // Tile geometry and number formats
  localparam int unsigned DIM       = 4;
  localparam int unsigned NUM_ACC   = DIM * DIM;
  localparam int unsigned IDX_BITS  = 2;
  localparam int unsigned ELEM_BITS = 16;                 // Q1.15
  localparam int unsigned PROD_BITS = 2 * ELEM_BITS;      // exact Q2.30
  localparam int unsigned ACC_BITS  = 48;                 // Q(ACC_BITS-30).30, range 40..64
  localparam int unsigned C_BITS    = 48;                 // Q18.30
  localparam int unsigned RD_BITS   = ((ACC_BITS > C_BITS) ? ACC_BITS : C_BITS) + 1;

  // Slave tdata layout, lowest bit first
  localparam int unsigned A_LSB      = 0;
  localparam int unsigned B_LSB      = A_LSB + DIM * ELEM_BITS;
  localparam int unsigned COLD_LSB   = B_LSB + DIM * ELEM_BITS;
  localparam int unsigned ROW_LSB    = COLD_LSB + C_BITS;
  localparam int unsigned COL_LSB    = ROW_LSB + IDX_BITS;
  localparam int unsigned S_USED     = COL_LSB + IDX_BITS;
  localparam int unsigned S_TDATA_W  = ((S_USED + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((C_BITS + 7) / 8) * 8;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DIM - 1);

  typedef enum logic {
    KIND_ACCUM   = 1'b0,
    KIND_READOUT = 1'b1
  } kind_t;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [RD_BITS-1:0]  C_MAX_W = {{(RD_BITS-C_BITS+1){1'b0}}, {(C_BITS-1){1'b1}}};
  localparam logic [RD_BITS-1:0]  C_MIN_W = {{(RD_BITS-C_BITS+1){1'b1}}, {(C_BITS-1){1'b0}}};

  // Accumulator plus product, clamped to the accumulator range
  function automatic logic [ACC_BITS-1:0] sat_acc_add(input logic [ACC_BITS-1:0] acc,
                                                      input logic [PROD_BITS-1:0] prod);
    logic [ACC_BITS:0] sum;
    sum = {acc[ACC_BITS-1], acc}
        + {{(ACC_BITS+1-PROD_BITS){prod[PROD_BITS-1]}}, prod};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      return sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_BITS-1:0];
  endfunction

  // Old C plus accumulator, clamped to the C range
  function automatic logic [C_BITS-1:0] sat_readout(input logic [C_BITS-1:0] c_old,
                                                    input logic [ACC_BITS-1:0] acc);
    logic [RD_BITS-1:0] sum;
    sum = {{(RD_BITS-C_BITS){c_old[C_BITS-1]}}, c_old}
        + {{(RD_BITS-ACC_BITS){acc[ACC_BITS-1]}}, acc};
    if ($signed(sum) > $signed(C_MAX_W)) begin
      return C_MAX_W[C_BITS-1:0];
    end
    if ($signed(sum) < $signed(C_MIN_W)) begin
      return C_MIN_W[C_BITS-1:0];
    end
    return sum[C_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/matmul_4x4_outer_product_tile_unit.sv
// Top level of the 4x4 outer-product tile unit: sixteen multipliers, sixteen
// saturating accumulators and a registered readout. Depends on mmtile_pkg.
//
//   channel  dir  signals                       fields (lowest bit up)
//   s_*      in   tvalid tready tdata tuser     tdata: a_elem0..3, b_elem0..3, c_old, row, col
//                                               tuser: kind
//   m_*      out  tvalid tready tdata tlast     tdata: c_value; tlast: last
//
// One request per cycle sustained while no readout is stalled. Products are
// registered on accept; accumulators update (or the readout is registered) once
// stage 1 fires. Reset clears the accumulators and both valid flags.
// A stalled result blocks the input only once a readout sits in stage 1;
// accumulate requests keep flowing past a full output register.
`default_nettype none

module matmul_4x4_outer_product_tile_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [mmtile_pkg::S_TDATA_W-1:0]     s_tdata,   // a_elem0..3, b_elem0..3, c_old, row, col
  input  wire                                  s_tuser,   // kind
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [mmtile_pkg::M_TDATA_W-1:0]     m_tdata,   // c_value
  output logic                                 m_tlast
);

  // Stage 1: registered products and readout fields
  logic                                  s1_valid;
  mmtile_pkg::kind_t                     s1_kind;
  logic [mmtile_pkg::PROD_BITS-1:0]      s1_prod [mmtile_pkg::NUM_ACC];
  logic [mmtile_pkg::C_BITS-1:0]         s1_c_old;
  logic [mmtile_pkg::IDX_BITS-1:0]       s1_row;
  logic [mmtile_pkg::IDX_BITS-1:0]       s1_col;

  logic [mmtile_pkg::ACC_BITS-1:0]       sums      [mmtile_pkg::NUM_ACC];
  logic [mmtile_pkg::ACC_BITS-1:0]       sums_next [mmtile_pkg::NUM_ACC];
  logic [mmtile_pkg::PROD_BITS-1:0]      prod_next [mmtile_pkg::NUM_ACC];

  logic                                  out_free;
  logic                                  s1_fire;
  logic                                  s1_last;
  logic [mmtile_pkg::C_BITS-1:0]         c_value_next;

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && ((s1_kind == mmtile_pkg::KIND_ACCUM) || out_free);
  assign s_tready = !s1_valid || s1_fire;
  assign s1_last  = (s1_row == mmtile_pkg::LAST_IDX) && (s1_col == mmtile_pkg::LAST_IDX);

  always_comb begin
    for (int r = 0; r < mmtile_pkg::DIM; r++) begin
      for (int c = 0; c < mmtile_pkg::DIM; c++) begin
        prod_next[r*mmtile_pkg::DIM + c] = mmtile_pkg::PROD_BITS'(
          $signed(s_tdata[mmtile_pkg::A_LSB + r*mmtile_pkg::ELEM_BITS +: mmtile_pkg::ELEM_BITS])
          * $signed(s_tdata[mmtile_pkg::B_LSB + c*mmtile_pkg::ELEM_BITS +: mmtile_pkg::ELEM_BITS]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      s1_kind  <= mmtile_pkg::kind_t'(s_tuser);
      s1_prod  <= prod_next;
      s1_c_old <= s_tdata[mmtile_pkg::COLD_LSB +: mmtile_pkg::C_BITS];
      s1_row   <= s_tdata[mmtile_pkg::ROW_LSB +: mmtile_pkg::IDX_BITS];
      s1_col   <= s_tdata[mmtile_pkg::COL_LSB +: mmtile_pkg::IDX_BITS];
    end
  end

  // Stage 2: accumulate, or read out and clear on the final element
  always_comb begin
    c_value_next = mmtile_pkg::sat_readout(s1_c_old, sums[{s1_row, s1_col}]);
    for (int i = 0; i < mmtile_pkg::NUM_ACC; i++) begin
      sums_next[i] = sums[i];
      if (s1_fire) begin
        if (s1_kind == mmtile_pkg::KIND_ACCUM) begin
          sums_next[i] = mmtile_pkg::sat_acc_add(sums[i], s1_prod[i]);
        end else if (s1_last) begin
          sums_next[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mmtile_pkg::NUM_ACC; i++) begin
        sums[i] <= '0;
      end
    end else begin
      sums <= sums_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && (s1_kind == mmtile_pkg::KIND_READOUT)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_fire && (s1_kind == mmtile_pkg::KIND_READOUT)) begin
      m_tdata <= mmtile_pkg::M_TDATA_W'(c_value_next);
      m_tlast <= s1_last;
    end
  end

  // Final readout leaves the first and last accumulators cleared
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_kind == mmtile_pkg::KIND_READOUT) && s1_last)
    |=> (sums[0] == '0) && (sums[mmtile_pkg::NUM_ACC-1] == '0))
    else $error("accumulators not cleared after final readout");

  // Every readout leaving stage 1 shows up as a result
  a_readout_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_kind == mmtile_pkg::KIND_READOUT)) |=> m_tvalid)
    else $error("readout request produced no result");

  // Input back-pressure only comes from a readout held behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && (s1_kind == mmtile_pkg::KIND_READOUT) && m_tvalid && !m_tready))
    else $error("input stalled without a blocked readout");

  // Accumulate requests never produce a result while none is pending
  a_accum_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_kind == mmtile_pkg::KIND_ACCUM) && !m_tvalid) |=> !m_tvalid)
    else $error("accumulate request produced a result");

endmodule

`default_nettype wire

### tb/tb_matmul_4x4_outer_product_tile_unit.sv
// Self-checking testbench for matmul_4x4_outer_product_tile_unit: predicts every
// readout from its own copy of the sixteen tile accumulators and checks each result.
// Depends on mmtile_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_matmul_4x4_outer_product_tile_unit;
  import mmtile_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int BIG_ITEMS   = 64;  // full-scale products before the sweep

  localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
  localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [C_BITS-1:0]    C_TOP    = {1'b0, {(C_BITS-1){1'b1}}};
  localparam logic signed [C_BITS-1:0]    C_BOTTOM = {1'b1, {(C_BITS-1){1'b0}}};

  typedef struct {
    kind_t                         kind;
    logic signed [ELEM_BITS-1:0]   a [DIM];
    logic signed [ELEM_BITS-1:0]   b [DIM];
    logic signed [C_BITS-1:0]      c_old;
    logic        [IDX_BITS-1:0]    row;
    logic        [IDX_BITS-1:0]    col;
  } tile_req_t;

  typedef struct packed {
    logic [C_BITS-1:0] c_value;
    logic              last;
  } c_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // a_elem0..3, b_elem0..3, c_old, row, col
  logic                 s_tuser  = 1'b0; // kind
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // c_value
  logic                 m_tlast;

  longint    tile_sum [NUM_ACC];
  c_result_t c_due_q [$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_len      = 0;
  int hold_orders   = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int fault_count   = 0;
  int n_sent        = 0;
  int n_accum       = 0;
  int n_readout     = 0;
  int n_checked     = 0;

  matmul_4x4_outer_product_tile_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_matmul_4x4_outer_product_tile_unit: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test orders one
  always @(posedge clk) begin
    if (hold_orders != hold_seen) begin
      hold_seen = hold_orders;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    c_result_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (c_due_q.size() == 0) begin
        $error("unexpected result: c_value %0d, last %0b",
               $signed(m_tdata[C_BITS-1:0]), m_tlast);
        fault_count++;
      end else begin
        due = c_due_q.pop_front();
        n_checked++;
        if (m_tdata[C_BITS-1:0] !== due.c_value) begin
          $error("c_value: expected %0d, got %0d",
                 $signed(due.c_value), $signed(m_tdata[C_BITS-1:0]));
          fault_count++;
        end
        if (m_tlast !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, m_tlast);
          fault_count++;
        end
      end
    end
  end

  // Tile model: saturating accumulate of the outer product, or readout of one sum
  task automatic tile_predict(input tile_req_t req);
    longint    prod, sum, acc_top, acc_bot, c_top, c_bot, lim;
    c_result_t res;
    int        r, c, idx;
    acc_top = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    acc_bot = -acc_top - 1;
    c_top   = (longint'(1) <<< (C_BITS - 1)) - 1;
    c_bot   = -c_top - 1;
    lim     = longint'(1) <<< C_BITS;
    if (req.kind == KIND_ACCUM) begin
      n_accum++;
      for (r = 0; r < DIM; r++) begin
        for (c = 0; c < DIM; c++) begin
          prod = longint'(req.a[r]) * longint'(req.b[c]);
          sum  = tile_sum[r*DIM + c] + prod;
          if (sum > acc_top) sum = acc_top;
          if (sum < acc_bot) sum = acc_bot;
          tile_sum[r*DIM + c] = sum;
        end
      end
    end else begin
      n_readout++;
      idx = int'(req.row) * DIM + int'(req.col);
      sum = tile_sum[idx];
      // wide accumulators clamp first; the C result saturates the same way
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      sum = sum + longint'(req.c_old);
      if (sum > c_top) sum = c_top;
      if (sum < c_bot) sum = c_bot;
      res.c_value = sum[C_BITS-1:0];
      res.last    = (req.row == LAST_IDX) && (req.col == LAST_IDX);
      c_due_q.push_back(res);
      if (res.last) begin
        for (r = 0; r < NUM_ACC; r++) tile_sum[r] = 0;
      end
    end
  endtask

  // Offer one request, wait for it to be taken, then maybe leave the bus idle
  task automatic send_req(input tile_req_t req);
    logic [S_TDATA_W-1:0] word;
    int                   i;
    word = '0;
    for (i = 0; i < DIM; i++) begin
      word[A_LSB + i*ELEM_BITS +: ELEM_BITS] = req.a[i];
      word[B_LSB + i*ELEM_BITS +: ELEM_BITS] = req.b[i];
    end
    word[COLD_LSB +: C_BITS]  = req.c_old;
    word[ROW_LSB +: IDX_BITS] = req.row;
    word[COL_LSB +: IDX_BITS] = req.col;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= req.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tile_predict(req);
    n_sent++;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic wait_all_returned();
    s_tvalid <= 1'b0;
    while (c_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  // Mostly full range, sometimes just inside either end so small sums saturate
  function automatic logic signed [C_BITS-1:0] rand_c_old();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return C_TOP - C_BITS'(raw[33:0]);
      1:       return C_BOTTOM + C_BITS'(raw[33:0]);
      default: return raw[C_BITS-1:0];
    endcase
  endfunction

  // Accumulate request; c_old, row and col carry junk since they are ignored
  function automatic tile_req_t accum_req(input logic [DIM*ELEM_BITS-1:0] a_pk,
                                          input logic [DIM*ELEM_BITS-1:0] b_pk);
    tile_req_t req;
    int        i;
    req.kind = KIND_ACCUM;
    for (i = 0; i < DIM; i++) begin
      req.a[i] = a_pk[i*ELEM_BITS +: ELEM_BITS];
      req.b[i] = b_pk[i*ELEM_BITS +: ELEM_BITS];
    end
    req.c_old = rand_c_old();
    req.row   = IDX_BITS'($urandom);
    req.col   = IDX_BITS'($urandom);
    return req;
  endfunction

  function automatic tile_req_t rand_accum();
    logic [DIM*ELEM_BITS-1:0] a_pk, b_pk;
    int                       i;
    for (i = 0; i < DIM; i++) begin
      a_pk[i*ELEM_BITS +: ELEM_BITS] = rand_elem();
      b_pk[i*ELEM_BITS +: ELEM_BITS] = rand_elem();
    end
    return accum_req(a_pk, b_pk);
  endfunction

  // Readout request; the A and B lanes carry junk
  function automatic tile_req_t readout_req(input logic [IDX_BITS-1:0] row,
                                            input logic [IDX_BITS-1:0] col,
                                            input logic signed [C_BITS-1:0] c_old);
    tile_req_t req;
    int        i;
    req.kind = KIND_READOUT;
    for (i = 0; i < DIM; i++) begin
      req.a[i] = ELEM_BITS'($urandom);
      req.b[i] = ELEM_BITS'($urandom);
    end
    req.c_old = c_old;
    req.row   = row;
    req.col   = col;
    return req;
  endfunction

  // Read back the whole tile in shuffled order, (3,3) last so it clears
  task automatic read_tile_sweep();
    int order [NUM_ACC-1];
    int i, j, t;
    for (i = 0; i < NUM_ACC - 1; i++) order[i] = i;
    for (i = NUM_ACC - 2; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < NUM_ACC - 1; i++) begin
      send_req(readout_req(IDX_BITS'(order[i] / DIM), IDX_BITS'(order[i] % DIM),
                           rand_c_old()));
    end
    send_req(readout_req(LAST_IDX, LAST_IDX, rand_c_old()));
  endtask

  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_req(readout_req(2'd0, 2'd0, '0));
    send_req(readout_req(LAST_IDX, LAST_IDX, C_TOP));
    send_req(accum_req({4{ELEM_MIN}}, {4{ELEM_MIN}}));
    send_req(accum_req({16'shffff, 16'sh0000, ELEM_MIN, ELEM_MAX},
                       {16'sh0000, 16'shffff, ELEM_MAX, ELEM_MIN}));
    send_req(accum_req({16'sh0001, ELEM_MIN, ELEM_MAX, ELEM_MAX},
                       {16'shffff, ELEM_MIN, ELEM_MIN, ELEM_MAX}));
    send_req(readout_req(2'd0, 2'd0, C_TOP));     // positive sum, clips high
    send_req(readout_req(2'd1, 2'd1, C_BOTTOM));  // negative sum, clips low
    send_req(readout_req(2'd2, 2'd3, '1));
    send_req(readout_req(2'd1, 2'd2, C_BOTTOM));
    send_req(readout_req(2'd3, 2'd0, 48'sh0000_4000_0000));
    send_req(readout_req(2'd0, 2'd3, C_TOP));
    send_req(readout_req(LAST_IDX, LAST_IDX, '0));
    send_req(readout_req(2'd0, 2'd0, 48'sd12345)); // tile must read zero now
    send_req(readout_req(LAST_IDX, LAST_IDX, C_BOTTOM));
    wait_all_returned();
  endtask

  // Run of full-scale products builds large sums of both signs before a sweep
  task automatic test_full_scale();
    int i;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    for (i = 0; i < BIG_ITEMS; i++) begin
      send_req(accum_req({ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN},
                         {ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN}));
    end
    send_req(readout_req(2'd0, 2'd0, '0));
    send_req(readout_req(2'd0, 2'd1, '0));
    for (i = 0; i < 12; i++) send_req(rand_accum());
    read_tile_sweep();
    wait_all_returned();
  endtask

  // Receiver holds off while readouts keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_len      = 150;
    hold_orders++;
    for (i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_req(rand_accum());
      else send_req(readout_req(IDX_BITS'($urandom), IDX_BITS'($urandom), rand_c_old()));
    end
    wait_all_returned();
  endtask

  task automatic test_random_mix(input int src_pct, input int snk_pct, input int count);
    int start, k, i;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    start         = n_sent;
    while (n_sent - start < count) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) send_req(rand_accum());
        read_tile_sweep();
      end else if ($urandom_range(1) == 0) begin
        send_req(rand_accum());
      end else begin
        send_req(readout_req(IDX_BITS'($urandom), IDX_BITS'($urandom), rand_c_old()));
      end
    end
    wait_all_returned();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_scale();
    test_backpressure();
    test_random_mix(0, 0, 130);
    test_random_mix(48, 0, 130);
    test_random_mix(0, 48, 130);
    test_random_mix(7, 7, 130);
    wait_all_returned();
    repeat (20) @(posedge clk);
    $display("Run covered %0d accumulate and %0d readout requests, %0d results checked,",
             n_accum, n_readout, n_checked);
    $display("incl. readout saturation, a held-off receiver and four idle/stall mixes.");
    if (fault_count == 0) begin
      $display("tb_matmul_4x4_outer_product_tile_unit: PASS");
    end else begin
      $display("tb_matmul_4x4_outer_product_tile_unit: FAIL");
    end
    $finish;
  end

endmodule
